// ===== hdl/cds_pkg.sv =====
// Shared constants and types of the concentric disk sampler.
// Used by every module of the block; depends on nothing else.
package cds_pkg;

    localparam int FRAC = 30;
    localparam int QUOT_BITS = FRAC + 1;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_COORD_BITS = 16;
    localparam logic [FRAC:0] ONE_Q = {1'b1, {FRAC{1'b0}}};
    localparam logic [FRAC-1:0] PIQ = 30'd843314857;
    localparam int DIV_STAGES = QUOT_BITS;
    localparam int SERIES_STEPS = 6;
    localparam int TRIG_STAGES = 2 + 3 * SERIES_STEPS;
    localparam int COS_DIV [SERIES_STEPS] = '{132, 90, 56, 30, 12, 2};
    localparam int SIN_DIV [SERIES_STEPS-1] = '{110, 72, 42, 20, 6};

    typedef enum logic [1:0] {
        WEDGE_E,
        WEDGE_N,
        WEDGE_W,
        WEDGE_S
    } wedge_t;

    typedef struct packed {
        logic   valid;
        logic   zero;
        logic   sneg;
        wedge_t wedge;
    } side_t;

endpackage

// ===== hdl/concentric_disk_sampler.sv =====
// Top level of the concentric square-to-disk sampler.
// Instantiates cds_front, cds_divider, cds_trig and cds_scale; uses cds_pkg.
//
// Usage:
//   A request is taken at each rising edge with start high and busy low.
//   busy is always low, so a new request may be given in every cycle.
//   u_first and u_second are unsigned Q0.SAMPLE_BITS fractions.
//   Each result appears on disk_x and disk_y for exactly one cycle, marked
//   by done, in the order the requests came in. Outputs are signed
//   Q1.(COORD_BITS-1); a value of +1 saturates to the largest code.
//   A request passes in order through the input stage, the bit-per-stage
//   divider, angle scaling and the six-step cosine and sine series, and
//   the scaling stage before done rises.
//   Throughput is one request per cycle; every stage is fully pipelined.
//   The receiver cannot stall, and none of the stages ever holds back.
//   Reset clears all valid bits at once, so no done pulse follows reset
//   until a request has travelled the full pipeline. There is no state
//   that survives between requests.
module concentric_disk_sampler #(
    parameter int SAMPLE_BITS = cds_pkg::DEF_SAMPLE_BITS,
    parameter int COORD_BITS = cds_pkg::DEF_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [SAMPLE_BITS-1:0]       u_first,
    input  logic [SAMPLE_BITS-1:0]       u_second,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] disk_x,
    output logic signed [COORD_BITS-1:0] disk_y
);

    localparam int DLY = cds_pkg::DIV_STAGES + cds_pkg::TRIG_STAGES;
    localparam int DIV_TAP = cds_pkg::DIV_STAGES - 1;

    cds_pkg::side_t                side0;
    logic [SAMPLE_BITS:0]          r0;
    logic [SAMPLE_BITS:0]          nmag0;
    logic [cds_pkg::QUOT_BITS-1:0] quot;
    logic [cds_pkg::FRAC:0]        cm, sm;
    cds_pkg::side_t                side_pipe_reg [0:DLY-1];
    logic [SAMPLE_BITS:0]          r_pipe_reg    [0:DLY-1];

    assign busy = 1'b0;

    cds_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (start && !busy),
        .u_first  (u_first),
        .u_second (u_second),
        .side_reg (side0),
        .r_reg    (r0),
        .nmag_reg (nmag0)
    );

    cds_divider #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_divider (
        .clk  (clk),
        .r    (r0),
        .nmag (nmag0),
        .quot (quot)
    );

    cds_trig u_trig (
        .clk (clk),
        .tq  (quot),
        .cm  (cm),
        .sm  (sm)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DLY; i++)
                side_pipe_reg[i] <= '0;
        end
        else
        begin
            side_pipe_reg[0] <= side0;
            for (int i = 1; i < DLY; i++)
                side_pipe_reg[i] <= side_pipe_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        r_pipe_reg[0] <= r0;
        for (int i = 1; i < DLY; i++)
            r_pipe_reg[i] <= r_pipe_reg[i-1];
    end

    cds_scale #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .side   (side_pipe_reg[DLY-1]),
        .r      (r_pipe_reg[DLY-1]),
        .cm     (cm),
        .sm     (sm),
        .done   (done),
        .disk_x (disk_x),
        .disk_y (disk_y)
    );

    a_front_num_le_radius: assert property (@(posedge clk) disable iff (!rst_n)
        side0.valid |-> nmag0 <= r0)
        else $error("numerator exceeds radius in the input stage");

    a_quot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        side_pipe_reg[DIV_TAP].valid && !side_pipe_reg[DIV_TAP].zero
        |-> quot <= cds_pkg::QUOT_BITS'(cds_pkg::ONE_Q))
        else $error("local fraction above one");

    a_trig_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        side_pipe_reg[DLY-1].valid && !side_pipe_reg[DLY-1].zero
        |-> cm <= cds_pkg::ONE_Q && sm <= cds_pkg::ONE_Q)
        else $error("cosine or sine magnitude above one");

    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        side_pipe_reg[DLY-1].valid && side_pipe_reg[DLY-1].zero
        |=> ##1 done && disk_x == '0 && disk_y == '0)
        else $error("origin request did not give a zero point");

endmodule

// ===== hdl/cds_front.sv =====
// Input stage: maps samples to [-1,1), picks the wedge, radius and numerator.
// Depends on cds_pkg.
module cds_front #(
    parameter int SAMPLE_BITS = cds_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid_in,
    input  logic [SAMPLE_BITS-1:0] u_first,
    input  logic [SAMPLE_BITS-1:0] u_second,
    output cds_pkg::side_t         side_reg,
    output logic [SAMPLE_BITS:0]   r_reg,
    output logic [SAMPLE_BITS:0]   nmag_reg
);

    logic signed [SAMPLE_BITS+1:0] sx, sy, nsx, nsy, rv, numv, nnum;
    logic [SAMPLE_BITS:0]          nmag;
    cds_pkg::wedge_t               wedge;
    cds_pkg::side_t                side_next;

    always_comb
    begin
        sx = $signed({1'b0, u_first, 1'b0}) - $signed({2'b01, {SAMPLE_BITS{1'b0}}});
        sy = $signed({1'b0, u_second, 1'b0}) - $signed({2'b01, {SAMPLE_BITS{1'b0}}});
        nsx = -sx;
        nsy = -sy;
        if (sx >= nsy)
        begin
            if (sx > sy)
            begin
                rv = sx;
                numv = sy;
                wedge = cds_pkg::WEDGE_E;
            end
            else
            begin
                rv = sy;
                numv = nsx;
                wedge = cds_pkg::WEDGE_N;
            end
        end
        else
        begin
            if (sx <= sy)
            begin
                rv = nsx;
                numv = nsy;
                wedge = cds_pkg::WEDGE_W;
            end
            else
            begin
                rv = nsy;
                numv = sx;
                wedge = cds_pkg::WEDGE_S;
            end
        end
        nnum = -numv;
        nmag = numv[SAMPLE_BITS+1] ? nnum[SAMPLE_BITS:0] : numv[SAMPLE_BITS:0];
        side_next.valid = valid_in;
        side_next.zero = (sx == '0) && (sy == '0);
        side_next.sneg = numv[SAMPLE_BITS+1];
        side_next.wedge = wedge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= rv[SAMPLE_BITS:0];
        nmag_reg <= nmag;
    end

endmodule

// ===== hdl/cds_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, giving the
// rounded local fraction nmag/r in Q.30. Depends on cds_pkg.
module cds_divider #(
    parameter int SAMPLE_BITS = cds_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            clk,
    input  logic [SAMPLE_BITS:0]            r,
    input  logic [SAMPLE_BITS:0]            nmag,
    output logic [cds_pkg::QUOT_BITS-1:0]   quot
);

    localparam int RB = SAMPLE_BITS + 1;
    localparam int QB = cds_pkg::QUOT_BITS;
    localparam int NS = cds_pkg::DIV_STAGES;

    logic [RB-1:0] rem_in  [0:NS];
    logic [QB-1:0] low_in  [0:NS];
    logic [QB-1:0] q_in    [0:NS];
    logic [RB-1:0] d_in    [0:NS];

    assign rem_in[0] = nmag >> 1;
    assign low_in[0] = {nmag[0], cds_pkg::FRAC'(r >> 1)};
    assign q_in[0] = '0;
    assign d_in[0] = r;

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic [RB:0]   trial;
        logic [RB:0]   diff;
        logic          qbit;
        logic [RB-1:0] rem_reg;
        logic [QB-1:0] low_reg;
        logic [QB-1:0] q_reg;
        logic [RB-1:0] d_reg;

        always_comb
        begin
            trial = {rem_in[i], low_in[i][QB-1]};
            diff = trial - {1'b0, d_in[i]};
            qbit = (trial >= {1'b0, d_in[i]});
        end

        always_ff @(posedge clk)
        begin
            rem_reg <= qbit ? diff[RB-1:0] : trial[RB-1:0];
            low_reg <= {low_in[i][QB-2:0], 1'b0};
            q_reg <= {q_in[i][QB-2:0], qbit};
            d_reg <= d_in[i];
        end

        assign rem_in[i+1] = rem_reg;
        assign low_in[i+1] = low_reg;
        assign q_in[i+1] = q_reg;
        assign d_in[i+1] = d_reg;
    end

    assign quot = q_in[NS];

endmodule

// ===== hdl/cds_trig.sv =====
// Angle scaling and pipelined Taylor series for cosine and sine in Q.30,
// three register stages per Horner step. Depends on cds_pkg.
module cds_trig (
    input  logic                          clk,
    input  logic [cds_pkg::QUOT_BITS-1:0] tq,
    output logic [cds_pkg::FRAC:0]        cm,
    output logic [cds_pkg::FRAC:0]        sm
);

    localparam int F = cds_pkg::FRAC;
    localparam int NS = cds_pkg::SERIES_STEPS;

    logic [2*F:0]   phi_prod;
    logic [2*F:0]   phi_sum;
    logic [F-1:0]   phi_reg;
    logic [2*F-1:0] sq_prod;
    logic [2*F-1:0] sq_sum;
    logic [F-1:0]   x2_reg;
    logic [F-1:0]   phi1_reg;

    logic [F:0]     acc_c [0:NS];
    logic [F:0]     acc_s [0:NS];
    logic [F-1:0]   x2_s  [0:NS];
    logic [F-1:0]   phi_s [0:NS];

    always_comb
    begin
        phi_prod = (2*F+1)'(tq) * (2*F+1)'(cds_pkg::PIQ);
        phi_sum = phi_prod + (2*F+1)'(cds_pkg::ONE_Q >> 1);
        sq_prod = (2*F)'(phi_reg) * (2*F)'(phi_reg);
        sq_sum = sq_prod + (2*F)'(cds_pkg::ONE_Q >> 1);
    end

    always_ff @(posedge clk)
    begin
        phi_reg <= phi_sum[2*F-1:F];
        x2_reg <= sq_sum[2*F-1:F];
        phi1_reg <= phi_reg;
    end

    assign acc_c[0] = cds_pkg::ONE_Q;
    assign acc_s[0] = cds_pkg::ONE_Q;
    assign x2_s[0] = x2_reg;
    assign phi_s[0] = phi1_reg;

    for (genvar j = 0; j < NS; j++)
    begin : g_step
        localparam int CDIV = cds_pkg::COS_DIV[j];
        localparam int CK = F + $clog2(CDIV);
        localparam logic [63:0] CM = ((64'd1 << CK) + 64'(CDIV) - 64'd1) / 64'(CDIV);

        logic [2*F:0]   pc_reg;
        logic [2*F:0]   ps_reg;
        logic [2*F+1:0] qc_reg;
        logic [2*F+1:0] qs_reg;
        logic [F-1:0]   x2a_reg, x2b_reg, x2c_reg;
        logic [F-1:0]   phia_reg, phib_reg, phic_reg;
        logic [F:0]     accc_reg;
        logic [F:0]     accs_reg;
        logic [F-1:0]   s_mult;

        assign s_mult = (j < NS - 1) ? x2_s[j] : phi_s[j];

        always_ff @(posedge clk)
        begin
            pc_reg <= (2*F+1)'(x2_s[j]) * (2*F+1)'(acc_c[j]);
            ps_reg <= (2*F+1)'(s_mult) * (2*F+1)'(acc_s[j]);
            x2a_reg <= x2_s[j];
            phia_reg <= phi_s[j];
            qc_reg <= (2*F+2)'(pc_reg[2*F-1:F]) * (2*F+2)'(CM[31:0]);
            x2b_reg <= x2a_reg;
            phib_reg <= phia_reg;
            accc_reg <= cds_pkg::ONE_Q - (F+1)'(qc_reg >> CK);
            x2c_reg <= x2b_reg;
            phic_reg <= phib_reg;
        end

        if (j < NS - 1)
        begin : g_sin_series
            localparam int SDIV = cds_pkg::SIN_DIV[j];
            localparam int SK = F + $clog2(SDIV);
            localparam logic [63:0] SM = ((64'd1 << SK) + 64'(SDIV) - 64'd1) / 64'(SDIV);

            always_ff @(posedge clk)
            begin
                qs_reg <= (2*F+2)'(ps_reg[2*F-1:F]) * (2*F+2)'(SM[31:0]);
                accs_reg <= cds_pkg::ONE_Q - (F+1)'(qs_reg >> SK);
            end
        end
        else
        begin : g_sin_final
            always_ff @(posedge clk)
            begin
                qs_reg <= (2*F+2)'(ps_reg[2*F-1:F]);
                accs_reg <= qs_reg[F:0];
            end
        end

        assign acc_c[j+1] = accc_reg;
        assign acc_s[j+1] = accs_reg;
        assign x2_s[j+1] = x2c_reg;
        assign phi_s[j+1] = phic_reg;
    end

    assign cm = acc_c[NS];
    assign sm = acc_s[NS];

endmodule

// ===== hdl/cds_scale.sv =====
// Output stage: wedge rotation, radius scaling, rounding and saturation to
// signed Q1.(COORD_BITS-1). Depends on cds_pkg.
module cds_scale #(
    parameter int SAMPLE_BITS = cds_pkg::DEF_SAMPLE_BITS,
    parameter int COORD_BITS = cds_pkg::DEF_COORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cds_pkg::side_t                side,
    input  logic [SAMPLE_BITS:0]          r,
    input  logic [cds_pkg::FRAC:0]        cm,
    input  logic [cds_pkg::FRAC:0]        sm,
    output logic                          done,
    output logic signed [COORD_BITS-1:0]  disk_x,
    output logic signed [COORD_BITS-1:0]  disk_y
);

    localparam int F = cds_pkg::FRAC;
    localparam int PW = SAMPLE_BITS + 1 + F + 1;
    localparam int SH = SAMPLE_BITS + 31 - COORD_BITS;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (COORD_BITS - 1);
    localparam logic [PW:0] MAXP = HALF - (PW+1)'(1);

    logic [F:0]    magx, magy;
    logic          negx, negy;
    logic [PW-1:0] px_reg, py_reg;
    logic          negx_reg, negy_reg;
    logic          zero_reg;
    logic          valid_reg;
    logic [PW:0]   mx, my;
    logic signed [COORD_BITS-1:0] x_next, y_next;

    function automatic logic [COORD_BITS-1:0] sat(input logic [PW:0] m, input logic neg);
        logic [PW:0] nm;
        begin
            nm = ~m + (PW+1)'(1);
            if (neg)
                sat = (m >= HALF) ? HALF[COORD_BITS-1:0] : nm[COORD_BITS-1:0];
            else
                sat = (m > MAXP) ? MAXP[COORD_BITS-1:0] : m[COORD_BITS-1:0];
        end
    endfunction

    always_comb
    begin
        case (side.wedge)
            cds_pkg::WEDGE_E:
            begin
                magx = cm; negx = 1'b0; magy = sm; negy = side.sneg;
            end
            cds_pkg::WEDGE_N:
            begin
                magx = sm; negx = !side.sneg; magy = cm; negy = 1'b0;
            end
            cds_pkg::WEDGE_W:
            begin
                magx = cm; negx = 1'b1; magy = sm; negy = !side.sneg;
            end
            default:
            begin
                magx = sm; negx = side.sneg; magy = cm; negy = 1'b1;
            end
        endcase
        mx = ((PW+1)'(px_reg) + ((PW+1)'(1) << (SH - 1))) >> SH;
        my = ((PW+1)'(py_reg) + ((PW+1)'(1) << (SH - 1))) >> SH;
        x_next = zero_reg ? '0 : sat(mx, negx_reg);
        y_next = zero_reg ? '0 : sat(my, negy_reg);
    end

    always_ff @(posedge clk)
    begin
        px_reg <= PW'(r) * PW'(magx);
        py_reg <= PW'(r) * PW'(magy);
        negx_reg <= negx;
        negy_reg <= negy;
        zero_reg <= side.zero;
        disk_x <= x_next;
        disk_y <= y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done <= 1'b0;
        end
        else
        begin
            valid_reg <= side.valid;
            done <= valid_reg;
        end
    end

endmodule
